@@ rtl/rgb_to_hsl_converter_macros.svh @@
//------------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Concurrent assertion helpers, clocked on i_clk and held off during reset.
//------------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define RHSL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rhsl assertion failed");
`define RHSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rhsl assertion failed");
`else
`define RHSL_ASSERT_IMPL(lbl, ante, cons)
`define RHSL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/rhsl_pkg.sv @@
//------------------------------------------------------------------------------
// RGB to HSL package
// Shared types, constants and the divider step used by every cell.
//------------------------------------------------------------------------------
package rhsl_pkg;

    localparam int unsigned NUM_CELLS  = 8;
    localparam logic [7:0]  SAT_SCALE  = 8'd240;
    localparam logic [5:0]  HUE_SCALE  = 6'd40;
    // floor(8*s/17) == (s * 30848) >> 16 for s <= 510
    localparam logic [14:0] LIGHT_RECIP = 15'd30848;

    // partial remainder, dividend bits shifting out / quotient bits shifting in
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] acc;
        logic [7:0] den;
    } t_lane;

    typedef struct packed {
        t_lane      sat;
        t_lane      hue;
        logic [7:0] light;
    } t_cell_data;

    function automatic t_lane f_div_step(input t_lane x);
        logic [8:0] t;
        logic [8:0] diff;
        logic       qbit;
        t_lane      y;
        t    = {x.rem, x.acc[7]};
        diff = t - {1'b0, x.den};
        qbit = (t >= {1'b0, x.den});
        y.den = x.den;
        y.rem = qbit ? diff[7:0] : t[7:0];
        y.acc = {x.acc[6:0], qbit};
        return y;
    endfunction

endpackage

@@ rtl/rhsl_front.sv @@
//------------------------------------------------------------------------------
// RGB to HSL front stage
// Max/min, lightness and the dividends and divisors for both divider chains.
//------------------------------------------------------------------------------
module rhsl_front import rhsl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_data o_data
);

    logic        r_valid;
    t_cell_data  r_data;
    t_cell_data  n_data;
    logic [7:0]  mx, mn, d;
    logic [8:0]  s;
    logic [8:0]  sden;
    logic [10:0] n;
    logic [15:0] sat_div, hue_div;
    logic [23:0] lprod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        mx = (mx > i_blue) ? mx : i_blue;
        mn = (i_red < i_green) ? i_red : i_green;
        mn = (mn < i_blue) ? mn : i_blue;
        d  = mx - mn;
        s  = {1'b0, mx} + {1'b0, mn};
        sden = (s <= 9'd255) ? s : (9'd510 - s);
        if (i_red == mx) begin
            n = (i_green == mn) ? (11'd5 * {3'b0, d} + {3'b0, mx - i_blue})
                                : ({3'b0, d} - {3'b0, mx - i_green});
        end else if (i_green == mx) begin
            n = (i_blue == mn) ? ({3'b0, d} + {3'b0, mx - i_red})
                               : (11'd3 * {3'b0, d} - {3'b0, mx - i_blue});
        end else begin
            n = (i_red == mn) ? (11'd3 * {3'b0, d} + {3'b0, mx - i_green})
                              : (11'd5 * {3'b0, d} - {3'b0, mx - i_red});
        end
        sat_div = {8'b0, d} * {8'b0, SAT_SCALE};
        hue_div = {5'b0, n} * {10'b0, HUE_SCALE};
        lprod   = {15'b0, s} * {9'b0, LIGHT_RECIP};
        if (d == 8'd0) begin
            n_data.sat = '{rem: 8'd0, acc: 8'd0, den: 8'd1};
            n_data.hue = '{rem: 8'd0, acc: 8'd0, den: 8'd1};
        end else begin
            n_data.sat = '{rem: sat_div[15:8], acc: sat_div[7:0], den: sden[7:0]};
            n_data.hue = '{rem: hue_div[15:8], acc: hue_div[7:0], den: d};
        end
        n_data.light = lprod[23:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ rtl/rhsl_cell.sv @@
//------------------------------------------------------------------------------
// RGB to HSL divider cell
// One restoring step for the saturation and hue quotients, one stage deep.
//------------------------------------------------------------------------------
`include "rgb_to_hsl_converter_macros.svh"

module rhsl_cell import rhsl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cell_data i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_data o_data
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.sat   = f_div_step(i_data.sat);
        n_data.hue   = f_div_step(i_data.hue);
        n_data.light = i_data.light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    `RHSL_ASSERT_IMPL(a_sat_rem, i_valid, i_data.sat.rem < i_data.sat.den)
    `RHSL_ASSERT_IMPL(a_hue_rem, i_valid, i_data.hue.rem < i_data.hue.den)
    `RHSL_ASSERT_NEXT(a_take, i_valid && o_ready, o_valid && (r_data == $past(n_data)))

endmodule

@@ rtl/rgb_to_hsl_converter.sv @@
//------------------------------------------------------------------------------
// RGB to HSL converter
// Pixel stream converter, 8-bit RGB in, hue/saturation/lightness on 0..240 out.
//------------------------------------------------------------------------------
// Input channel s_axis carries one pixel per request: red, green, blue.
// Output channel m_axis carries hue, saturation and lightness, each 0..240,
// exact truncated values. Grey pixels give hue 0 and saturation 0.
// The pipe is one front stage (max/min, lightness, dividends) and
// a row of 8 divider cells, each retiring one quotient bit of both the
// saturation and hue divisions.
// Throughput is one pixel per cycle while m_axis_tready is high; every stage holds one pixel.
// Each stage has its own valid bit and takes a new pixel whenever it is
// empty or its neighbor takes its pixel, so bubbles close up while the
// receiver stalls; a full pipe of 9 pixels then holds s_axis_tready low.
// Reset (synchronous, i_rst_n low) empties the pipe; no data is lost
// beyond what was in flight.
//------------------------------------------------------------------------------
module rgb_to_hsl_converter import rhsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // hue [7:0], saturation [15:8], lightness [23:16]
);

    logic       valid [NUM_CELLS+1];
    logic       ready [NUM_CELLS+1];
    t_cell_data data  [NUM_CELLS+1];

    rhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_valid (valid[0]),
        .i_ready (ready[0]),
        .o_data  (data[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rhsl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .o_ready (ready[k]),
            .i_data  (data[k]),
            .o_valid (valid[k+1]),
            .i_ready (ready[k+1]),
            .o_data  (data[k+1])
        );
    end

    assign ready[NUM_CELLS] = m_axis_tready;
    assign m_axis_tvalid    = valid[NUM_CELLS];
    assign m_axis_tdata     = {data[NUM_CELLS].light, data[NUM_CELLS].sat.acc,
                               data[NUM_CELLS].hue.acc};

endmodule
